>>> rtl/status_frame_receiver_top_assert.svh
// assertion macros used by the status frame receiver checker
`ifndef STATUS_FRAME_RECEIVER_TOP_ASSERT_SVH
`define STATUS_FRAME_RECEIVER_TOP_ASSERT_SVH

// same-cycle implication, disabled while reset is high
`define SFR_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("status frame receiver check failed");

// next-cycle implication, disabled while reset is high
`define SFR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("status frame receiver check failed");

`endif

>>> rtl/sfr_pkg.sv
// shared types and constants for the status frame receiver
`default_nettype none
package sfr_pkg;

   localparam logic [7:0] StartByte = 8'h20;
   localparam int FrameLen = 12;
   localparam int StoreDepth = FrameLen - 1;
   localparam int CountWidth = $clog2(FrameLen);
   localparam int QueueDepthDefault = 2;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic [7:0] awaited_command;
   } req_type;

   typedef struct packed {
      logic        frame_ok;
      logic [7:0]  reply_code;
      logic [7:0]  fan_speed;
      logic [7:0]  brightness;
      logic [7:0]  color_temp;
      logic [15:0] timer_value;
      logic [7:0]  stage;
      logic        answers_awaited;
      logic        update_fan;
      logic        update_light;
   } rsp_type;

   // decoded frame handed from the front to the back
   typedef struct packed {
      logic        frame_ok;
      logic [7:0]  reply_code;
      logic [7:0]  fan_speed;
      logic [7:0]  brightness;
      logic [7:0]  color_temp;
      logic [15:0] timer_value;
      logic [7:0]  stage;
      logic        answers_awaited;
   } frame_type;

endpackage
`default_nettype wire

>>> rtl/sfr_front.sv
// front end: start byte hunt, frame collection, checksum and decode
`default_nettype none
module sfr_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire sfr_pkg::req_type  req_data,
   input  wire logic              q_full,
   output logic                   push_valid,
   output sfr_pkg::frame_type     push_data
);
   import sfr_pkg::*;

   logic [CountWidth-1:0] count_ff, count_in;
   logic [7:0]            xor_ff, xor_in;
   logic [7:0]            store_ff [StoreDepth-1:1];
   logic                  accept;
   logic                  last_byte;
   logic                  sum_ok;

   // a request is taken whenever the queue has room
   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign last_byte = (count_ff == CountWidth'(StoreDepth));
   assign sum_ok    = (req_data.rx_byte == xor_ff);

   // byte counter and running xor
   always_comb begin
      count_in = count_ff;
      xor_in   = xor_ff;
      if (accept) begin
         priority if (count_ff == '0) begin
            if (req_data.rx_byte == StartByte) begin
               count_in = CountWidth'(1);
               xor_in   = StartByte;
            end
         end else if (last_byte) begin
            count_in = '0;
            xor_in   = '0;
         end else begin
            count_in = count_ff + CountWidth'(1);
            xor_in   = xor_ff ^ req_data.rx_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         xor_ff   <= '0;
      end else begin
         count_ff <= count_in;
         xor_ff   <= xor_in;
      end
   end

   // frame body bytes
   always_ff @(posedge clock) begin
      if (accept && count_ff != '0 && !last_byte) begin
         store_ff[count_ff] <= req_data.rx_byte;
      end
   end

   // decoded frame, all zero on a checksum mismatch
   always_comb begin
      push_valid = accept && last_byte;
      push_data  = '0;
      if (sum_ok) begin
         push_data.frame_ok        = 1'b1;
         push_data.reply_code      = store_ff[1];
         push_data.fan_speed       = store_ff[4];
         push_data.brightness      = store_ff[5];
         push_data.color_temp      = store_ff[6];
         push_data.timer_value     = {store_ff[8], store_ff[7]};
         push_data.stage           = store_ff[10];
         push_data.answers_awaited = (req_data.awaited_command != 8'd0) &&
                                     (req_data.awaited_command == store_ff[1]);
      end
   end

endmodule
`default_nettype wire

>>> rtl/sfr_queue.sv
// short first-in first-out queue of decoded frames
`default_nettype none
module sfr_queue #(
   parameter int Depth = sfr_pkg::QueueDepthDefault
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push_valid,
   input  wire sfr_pkg::frame_type  push_data,
   output logic                     full,
   output logic                     pop_valid,
   input  wire logic                pop_ready,
   output sfr_pkg::frame_type       pop_data
);
   import sfr_pkg::*;

   localparam int PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntWidth = $clog2(Depth + 1);

   frame_type             entry_ff [Depth];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0]   cnt_ff, cnt_in;
   logic                  do_push, do_pop;

   assign full      = (cnt_ff == CntWidth'(Depth));
   assign pop_valid = (cnt_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop_valid && pop_ready;

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : wr_ptr_ff + PtrWidth'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : rd_ptr_ff + PtrWidth'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CntWidth'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CntWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

>>> rtl/sfr_back.sv
// back end: change detection against the last good status, output register
`default_nettype none
module sfr_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_wr_en,
   input  wire logic [7:0]          csr_wr_data,
   input  wire logic                pop_valid,
   output logic                     pop_ready,
   input  wire sfr_pkg::frame_type  pop_data,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output sfr_pkg::rsp_type         rsp_data
);
   import sfr_pkg::*;

   logic [7:0] keepalive_ff;
   logic [7:0] last_fan_ff, last_stage_ff, last_bright_ff, last_color_ff;
   logic       have_last_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_data_ff, rsp_data_in;
   logic       take;
   logic       change_only;

   assign pop_ready = !rsp_valid_ff || !rsp_stall;
   assign take      = pop_valid && pop_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // keepalive command register
   always_ff @(posedge clock) begin
      if (reset) begin
         keepalive_ff <= '0;
      end else if (csr_wr_en) begin
         keepalive_ff <= csr_wr_data;
      end
   end

   // update flags for the frame leaving the queue
   assign change_only = (pop_data.reply_code == keepalive_ff) && have_last_ff;

   always_comb begin
      rsp_data_in.frame_ok        = pop_data.frame_ok;
      rsp_data_in.reply_code      = pop_data.reply_code;
      rsp_data_in.fan_speed       = pop_data.fan_speed;
      rsp_data_in.brightness      = pop_data.brightness;
      rsp_data_in.color_temp      = pop_data.color_temp;
      rsp_data_in.timer_value     = pop_data.timer_value;
      rsp_data_in.stage           = pop_data.stage;
      rsp_data_in.answers_awaited = pop_data.answers_awaited;
      rsp_data_in.update_fan      = 1'b0;
      rsp_data_in.update_light    = 1'b0;
      if (pop_data.frame_ok) begin
         rsp_data_in.update_fan   = !change_only ||
                                    (pop_data.fan_speed != last_fan_ff) ||
                                    (pop_data.stage != last_stage_ff);
         rsp_data_in.update_light = !change_only ||
                                    (pop_data.brightness != last_bright_ff) ||
                                    (pop_data.color_temp != last_color_ff);
      end
   end

   // last good status
   always_ff @(posedge clock) begin
      if (reset) begin
         last_fan_ff    <= '0;
         last_stage_ff  <= '0;
         last_bright_ff <= '0;
         last_color_ff  <= '0;
         have_last_ff   <= 1'b0;
      end else if (take && pop_data.frame_ok) begin
         last_fan_ff    <= pop_data.fan_speed;
         last_stage_ff  <= pop_data.stage;
         last_bright_ff <= pop_data.brightness;
         last_color_ff  <= pop_data.color_temp;
         have_last_ff   <= 1'b1;
      end
   end

   // output register
   assign rsp_valid_in = take ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule
`default_nettype wire

>>> rtl/status_frame_receiver_top.sv
// status frame receiver (front, queue, back): one request per cycle while the queue
// has room; a frame is queued on its twelfth byte, then shown in the result register
// throughput: one request per cycle, limited only by queue room when rsp side stalls
// queue holds QueueDepth decoded frames between front and back
// synchronous active-high reset clears counter, xor, queue, last status and the
// keepalive register; no clearing pass
`default_nettype none
module status_frame_receiver_top #(
   parameter int QueueDepth = sfr_pkg::QueueDepthDefault
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire sfr_pkg::req_type  req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output sfr_pkg::rsp_type       rsp_data,
   input  wire logic              csr_wr_en,
   input  wire logic [7:0]        csr_wr_data
);
   import sfr_pkg::*;

   logic      q_full;
   logic      push_valid;
   frame_type push_data;
   logic      pop_valid;
   logic      pop_ready;
   frame_type pop_data;

   // front: hunt, collect, checksum
   sfr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .q_full     (q_full),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   // decoupling queue
   sfr_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (q_full),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // back: change detection and result register
   sfr_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .pop_valid   (pop_valid),
      .pop_ready   (pop_ready),
      .pop_data    (pop_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule
`default_nettype wire

>>> rtl/sfr_checker.sv
// port-level checks for the status frame receiver and their bind
`default_nettype none
`include "status_frame_receiver_top_assert.svh"
module sfr_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire sfr_pkg::rsp_type  rsp_data
);
   import sfr_pkg::*;

   logic rsp_held;
   logic rsp_bad;
   logic rsp_upd;
   logic rsp_match;

   // terms watched on the result channel
   assign rsp_held  = rsp_valid && rsp_stall;
   assign rsp_bad   = rsp_valid && !rsp_data.frame_ok;
   assign rsp_upd   = rsp_valid && (rsp_data.update_fan || rsp_data.update_light);
   assign rsp_match = rsp_valid && rsp_data.answers_awaited;

   // a stalled result holds
   `SFR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_held, rsp_valid && $stable(rsp_data))

   // a bad frame carries nothing but zeros
   `SFR_ASSERT_IMP(a_bad_zero, clock, reset, rsp_bad, rsp_data == '0)

   // update requests only come from good frames
   `SFR_ASSERT_IMP(a_upd_good, clock, reset, rsp_upd, rsp_data.frame_ok)

   // a match never names the idle command code
   `SFR_ASSERT_IMP(a_match_nz, clock, reset, rsp_match, rsp_data.reply_code != 8'd0)

endmodule

bind status_frame_receiver_top sfr_checker u_sfr_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
`default_nettype wire
